// ===== sv/base64_stream_codec_assert.svh =====
// ----------------------------------------------------------------------------
// base64_stream_codec assertion macros
// Shared assertion forms for the codec modules. Each expects clk_i in scope,
// and B64SC_ASSERT also expects rst_ni.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_CODEC_ASSERT_SVH
`define BASE64_STREAM_CODEC_ASSERT_SVH

// Checked only outside reset.
`define B64SC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define B64SC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== sv/b64sc_pkg.sv =====
// ----------------------------------------------------------------------------
// b64sc_pkg
// Types, constants and character mapping functions shared by the codec.
// ----------------------------------------------------------------------------
`default_nettype none

package b64sc_pkg;

  localparam logic [7:0] PadChar = 8'h3D;

  // Register indexes of the configuration port.
  localparam logic RegDecodeMode = 1'b0;

  // Position in the four-symbol group, one-hot.
  typedef enum logic [3:0] {
    PH0 = 4'b0001,
    PH1 = 4'b0010,
    PH2 = 4'b0100,
    PH3 = 4'b1000
  } phase_e;

  // One queue entry: all result bytes caused by one input item.
  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] data;
  } job_t;

  // Configuration write seen by the front end.
  typedef struct packed {
    logic we;
    logic decode_mode;
  } cfg_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } sym_t;

  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26) begin
      r = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      r = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      r = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      r = 8'h2B;
    end else begin
      r = 8'h2F;
    end
    return r;
  endfunction

  function automatic sym_t sym_value(input logic [7:0] c);
    sym_t s;
    s = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      s.ok  = 1'b1;
      s.val = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      s.ok  = 1'b1;
      s.val = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s.ok  = 1'b1;
      s.val = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      s.ok  = 1'b1;
      s.val = 6'd62;
    end else if (c == 8'h2F) begin
      s.ok  = 1'b1;
      s.val = 6'd63;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== sv/base64_stream_codec.sv =====
// ----------------------------------------------------------------------------
// base64_stream_codec
// Streaming base64 encoder and decoder with the mode chosen by a register.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid_i, in_stall_o, data_byte_i,
// end_of_stream_i) carries one byte or an end-of-stream marker per transfer.
// The output channel (out_valid_o, out_stall_i, out_byte_o, last_of_run_o)
// carries one result byte per transfer; last_of_run_o marks the final byte
// caused by an input item. Items that cause no result produce no transfer.
// The APB register at address 0 selects the mode (bit 0: 0 encode, 1 decode);
// writing it also restarts the group; the user must write it only while idle, as the block does not enforce this.
// The first result of an item passes through the job queue and then the output
// register before it is valid. The single output register moves one byte per
// cycle while out_stall_i is low, so an item holds the output for as many
// transfers as it has results; encoding gives one or two bytes per input byte
// and a padded flush gives two or three.
// Reset clears the mode to encode, the group phase, the queue and the output.
// When the receiver stalls, the current byte holds; the front keeps taking
// items until the job queue (QueueDepth entries) fills, then stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_stream_codec #(
  parameter int QueueDepth = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // Input channel.
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        end_of_stream_i,
  // Output channel.
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             last_of_run_o
);
  import b64sc_pkg::*;

  cfg_t cfg;
  logic decode_mode;
  logic push, pop, q_full, q_valid;
  job_t push_job, pop_job;

  // Writes complete in the access phase; the index comes from the word address.
  assign pready          = 1'b1;
  assign cfg.we          = psel && penable && pwrite && (paddr[2] == RegDecodeMode);
  assign cfg.decode_mode = pwdata[0];
  assign prdata          = (paddr[2] == RegDecodeMode) ? {31'b0, decode_mode} : '0;

  // Front end: takes each item, updates the group phase and carry bits, and
  // hands all the item's result bytes to the queue as a single job.
  b64sc_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .end_of_stream_i (end_of_stream_i),
    .q_full_i        (q_full),
    .push_o          (push),
    .job_o           (push_job),
    .decode_mode_o   (decode_mode)
  );

  // The queue decouples the two sides so either may stall on its own.
  b64sc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .pop_job_o  (pop_job),
    .full_o     (q_full),
    .valid_o    (q_valid)
  );

  // Back end: plays out one byte per transfer and loads the next job as the
  // last byte of the current one leaves.
  b64sc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_job_i       (pop_job),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

`default_nettype wire

// ===== sv/b64sc_front.sv =====
// ----------------------------------------------------------------------------
// b64sc_front
// Accepts input items, advances the group phase and builds the result job.
// ----------------------------------------------------------------------------
`default_nettype none

module b64sc_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire b64sc_pkg::cfg_t cfg_i,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic [7:0]    data_byte_i,
  input  wire logic          end_of_stream_i,
  input  wire logic          q_full_i,
  output logic               push_o,
  output b64sc_pkg::job_t    job_o,
  output logic               decode_mode_o
);
  import b64sc_pkg::*;

  phase_e     phase_q, phase_d;
  logic [7:0] carry_q, carry_d;
  logic       mode_q, mode_d;
  logic       accept;
  sym_t       sym;
  job_t       job;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign sym        = sym_value(data_byte_i);

  always_comb begin
    phase_d = phase_q;
    carry_d = carry_q;
    mode_d  = mode_q;
    job     = '0;
    if (cfg_i.we) begin
      mode_d  = cfg_i.decode_mode;
      phase_d = PH0;
      carry_d = '0;
    end else if (accept) begin
      if (!mode_q) begin
        if (end_of_stream_i) begin
          // Flush leftover bits, then one or two pads.
          if (phase_q == PH1 || phase_q == PH2) begin
            job.data[0] = enc_char(carry_q[5:0]);
            job.data[1] = PadChar;
            job.data[2] = PadChar;
            job.cnt     = (phase_q == PH1) ? 2'd3 : 2'd2;
          end
          phase_d = PH0;
          carry_d = '0;
        end else begin
          unique case (phase_q)
            PH1: begin
              job.data[0] = enc_char({carry_q[5:4], data_byte_i[7:4]});
              job.cnt     = 2'd1;
              carry_d     = {2'b00, data_byte_i[3:0], 2'b00};
              phase_d     = PH2;
            end
            PH2: begin
              job.data[0] = enc_char({carry_q[5:2], data_byte_i[7:6]});
              job.data[1] = enc_char(data_byte_i[5:0]);
              job.cnt     = 2'd2;
              carry_d     = '0;
              phase_d     = PH0;
            end
            default: begin
              job.data[0] = enc_char(data_byte_i[7:2]);
              job.cnt     = 2'd1;
              carry_d     = {2'b00, data_byte_i[1:0], 4'b0000};
              phase_d     = PH1;
            end
          endcase
        end
      end else if (end_of_stream_i) begin
        phase_d = PH0;
        carry_d = '0;
      end else if (sym.ok) begin
        unique case (phase_q)
          PH1: begin
            job.data[0] = carry_q | {6'b0, sym.val[5:4]};
            job.cnt     = 2'd1;
            carry_d     = {sym.val[3:0], 4'b0000};
            phase_d     = PH2;
          end
          PH2: begin
            job.data[0] = carry_q | {4'b0, sym.val[5:2]};
            job.cnt     = 2'd1;
            carry_d     = {sym.val[1:0], 6'b0};
            phase_d     = PH3;
          end
          PH3: begin
            job.data[0] = carry_q | {2'b0, sym.val};
            job.cnt     = 2'd1;
            carry_d     = '0;
            phase_d     = PH0;
          end
          default: begin
            carry_d = {sym.val, 2'b00};
            phase_d = PH1;
          end
        endcase
      end
    end
  end

  assign push_o        = accept && (job.cnt != 2'd0);
  assign job_o         = job;
  assign decode_mode_o = mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH0;
      carry_q <= '0;
      mode_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      carry_q <= carry_d;
      mode_q  <= mode_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/b64sc_queue.sv =====
// ----------------------------------------------------------------------------
// b64sc_queue
// Small job queue between the front end and the output serializer.
// ----------------------------------------------------------------------------
`default_nettype none
`include "base64_stream_codec_assert.svh"

module b64sc_queue #(
  parameter int Depth = 2
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire b64sc_pkg::job_t push_job_i,
  input  wire logic            pop_i,
  output b64sc_pkg::job_t      pop_job_o,
  output logic                 full_o,
  output logic                 valid_o
);
  import b64sc_pkg::*;

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign valid_o   = (cnt_q != '0);
  assign pop_job_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  `B64SC_ASSERT(a_cnt_bound, cnt_q <= CntW'(Depth), "queue occupancy above depth")
  `B64SC_ASSERT(a_no_pop_empty, pop_i |-> (cnt_q != '0), "pop from empty queue")
  `B64SC_ASSERT(a_push_grows, (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + 1'b1), "push lost")

endmodule

`default_nettype wire

// ===== sv/b64sc_back.sv =====
// ----------------------------------------------------------------------------
// b64sc_back
// Serializes queued jobs onto the output channel, one byte per transfer.
// ----------------------------------------------------------------------------
`default_nettype none
`include "base64_stream_codec_assert.svh"

module b64sc_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            q_valid_i,
  input  wire b64sc_pkg::job_t q_job_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic [7:0]           out_byte_o,
  output logic                 last_of_run_o
);
  import b64sc_pkg::*;

  logic       busy_q, busy_d;
  job_t       job_q, job_d;
  logic [1:0] idx_q, idx_d;
  logic       last;
  logic       fire;

  assign last = (idx_q == job_q.cnt - 2'd1);
  assign fire = busy_q && !out_stall_i;
  assign pop_o = q_valid_i && (!busy_q || (fire && last));

  always_comb begin
    busy_d = busy_q;
    job_d  = job_q;
    idx_d  = idx_q;
    if (pop_o) begin
      busy_d = 1'b1;
      job_d  = q_job_i;
      idx_d  = '0;
    end else if (fire) begin
      if (last) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  assign out_valid_o   = busy_q;
  assign out_byte_o    = job_q.data[idx_q];
  assign last_of_run_o = last;

  `B64SC_ASSERT(a_idx_in_job, busy_q |-> ((job_q.cnt != 2'd0) && (idx_q < job_q.cnt)), "byte index outside job")
  `B64SC_ASSERT(a_idle_after_last, (fire && last && !q_valid_i) |=> !busy_q, "serializer stuck after last byte")

endmodule

`default_nettype wire
